// ----- design/lgr_pkg.sv -----
package lgr_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int CHANNELS_DEF  = 4;
    localparam int MAX_BURST_DEF = 64;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 32;
    localparam int GRID_W  = TIME_W + 2;
    localparam int WFRAC   = 24;
    localparam int MAG_W   = 31;
    localparam int DIV_NW  = TIME_W + WFRAC + 2;
    localparam int DIV_QW  = TIME_W;
    localparam int N_PORTS = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int ORDER_W = 4;
    localparam int CHSEL_W = 3;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_ORDER = 2'd2;
    localparam logic [1:0] REG_CHAN  = 2'd3;

    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_GINIT  = 4'd2;
    localparam logic [3:0] OP_GFIX   = 4'd3;
    localparam logic [3:0] OP_NODE   = 4'd4;
    localparam logic [3:0] OP_PAIR   = 4'd5;
    localparam logic [3:0] OP_FLOAD  = 4'd6;
    localparam logic [3:0] OP_FMUL   = 4'd7;
    localparam logic [3:0] OP_WRND   = 4'd8;
    localparam logic [3:0] OP_WSTORE = 4'd9;
    localparam logic [3:0] OP_CCLR   = 4'd10;
    localparam logic [3:0] OP_CMUL   = 4'd11;
    localparam logic [3:0] OP_CACC   = 4'd12;
    localparam logic [3:0] OP_CSTORE = 4'd13;
    localparam logic [3:0] OP_EMIT   = 4'd14;
    localparam logic [3:0] OP_SFIX   = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       cap;
    } lgr_cmd_t;

    typedef struct packed {
        logic filling;
        logic fill_last;
        logic grid_below;
        logic g_le_lim;
        logic den_zero;
        logic ratio_ovf;
        logic div_done;
        logic out_free;
        logic next_last;
        logic next_skip;
    } lgr_stat_t;

endpackage

// ----- design/lgr_in_if.sv -----
interface lgr_in_if;
    import lgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        sample_time;
    logic signed [VAL_W-1:0]  value_a;
    logic signed [VAL_W-1:0]  value_b;
    logic signed [VAL_W-1:0]  value_c;
    logic signed [VAL_W-1:0]  value_d;

    modport source (output valid, sample_time, value_a, value_b, value_c, value_d,
                    input ready);
    modport sink (input valid, sample_time, value_a, value_b, value_c, value_d,
                  output ready);
endinterface

// ----- design/lgr_out_if.sv -----
interface lgr_out_if;
    import lgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        grid_time_out;
    logic signed [VAL_W-1:0]  interp_a;
    logic signed [VAL_W-1:0]  interp_b;
    logic signed [VAL_W-1:0]  interp_c;
    logic signed [VAL_W-1:0]  interp_d;
    logic                     last_of_burst;
    logic                     points_skipped;

    modport source (output valid, grid_time_out, interp_a, interp_b, interp_c, interp_d,
                    last_of_burst, points_skipped, input ready);
    modport sink (input valid, grid_time_out, interp_a, interp_b, interp_c, interp_d,
                  last_of_burst, points_skipped, output ready);
endinterface

// ----- design/lgr_div.sv -----
module lgr_div #(
    parameter int NW = lgr_pkg::DIV_NW,
    parameter int QW = lgr_pkg::DIV_QW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [QW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot,
    output logic [QW-1:0] rem
);
    localparam int CNT_W = $clog2(QW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [QW-1:0]     rem_reg;
    logic [QW-1:0]     sh_reg;
    logic [QW-1:0]     den_reg;
    logic [QW:0]       trial;
    logic              ge;
    logic [QW:0]       diff;

    // The caller guarantees that the upper part of the numerator is below the divisor.
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= QW'(num[NW-1:QW]);
            sh_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[QW-1:0] : trial[QW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;
    assign rem  = rem_reg;
endmodule

// ----- design/lgr_ctrl.sv -----
module lgr_ctrl #(
    parameter int MAX_ORDER = lgr_pkg::MAX_ORDER_DEF,
    parameter int CHANNELS  = lgr_pkg::CHANNELS_DEF,
    parameter int MAX_BURST = lgr_pkg::MAX_BURST_DEF,
    parameter int IDX_W     = $clog2(MAX_ORDER),
    parameter int FC_W      = $clog2(MAX_ORDER + 1),
    parameter int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    parameter int NCH_W     = $clog2(CHANNELS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [FC_W-1:0]   ord,
    input  logic [NCH_W-1:0]  nch,
    input  lgr_pkg::lgr_stat_t stat,
    output lgr_pkg::lgr_cmd_t  cmd,
    output logic [IDX_W-1:0]  t_idx,
    output logic [IDX_W-1:0]  w_idx,
    output logic [CH_W-1:0]   ch_idx,
    output logic              in_ready
);
    import lgr_pkg::*;

    localparam int N_W = $clog2(MAX_BURST + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GINIT  = 4'd1;
    localparam logic [3:0] S_GWAIT  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_NODE   = 4'd4;
    localparam logic [3:0] S_PAIR   = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ROUND  = 4'd8;
    localparam logic [3:0] S_NEND   = 4'd9;
    localparam logic [3:0] S_CCLR   = 4'd10;
    localparam logic [3:0] S_CMUL   = 4'd11;
    localparam logic [3:0] S_CACC   = 4'd12;
    localparam logic [3:0] S_CSTORE = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;
    localparam logic [3:0] S_SWAIT  = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CH_W-1:0]  c_reg, c_next;
    logic [N_W-1:0]   n_reg, n_next;

    logic [FC_W-1:0]  mid;
    logic [FC_W-1:0]  lim;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] mid_idx;
    logic [IDX_W-1:0] lim_idx;
    logic [CH_W-1:0]  last_ch;
    logic             cap;

    assign mid      = ord >> 1;
    assign lim      = (mid + 1'b1 > ord - 1'b1) ? ord - 1'b1 : mid + 1'b1;
    assign last_idx = IDX_W'(ord - 1'b1);
    assign mid_idx  = IDX_W'(mid);
    assign lim_idx  = IDX_W'(lim);
    assign last_ch  = CH_W'(nch - 1'b1);
    assign cap      = n_reg == N_W'(MAX_BURST - 1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        cmd.op     = OP_NOP;
        cmd.cap    = 1'b0;
        t_idx      = j_reg;
        w_idx      = i_reg;
        ch_idx     = c_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.op = OP_LOAD;
                    if (stat.filling)
                        state_next = stat.fill_last ? S_GINIT : S_IDLE;
                    else
                        state_next = S_CHECK;
                end
            end
            S_GINIT:
            begin
                t_idx      = mid_idx;
                cmd.op     = OP_GINIT;
                state_next = stat.grid_below ? S_GWAIT : S_CHECK;
            end
            S_GWAIT:
            begin
                t_idx  = mid_idx;
                cmd.op = OP_GFIX;
                if (stat.div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                t_idx      = lim_idx;
                n_next     = '0;
                i_next     = '0;
                state_next = stat.g_le_lim ? S_NODE : S_IDLE;
            end
            S_NODE:
            begin
                t_idx      = i_reg;
                cmd.op     = OP_NODE;
                j_next     = '0;
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                if (j_reg == i_reg)
                begin
                    if (j_reg == last_idx)
                        state_next = S_NEND;
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                begin
                    cmd.op = OP_PAIR;
                    if (stat.den_zero)
                        state_next = S_NEND;
                    else if (stat.ratio_ovf)
                        state_next = S_MUL;
                    else
                        state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                cmd.op = OP_FLOAD;
                if (stat.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_FMUL;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.op = OP_WRND;
                if (j_reg == last_idx)
                    state_next = S_NEND;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PAIR;
                end
            end
            S_NEND:
            begin
                cmd.op = OP_WSTORE;
                if (i_reg == last_idx)
                    state_next = S_CCLR;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_NODE;
                end
            end
            S_CCLR:
            begin
                cmd.op     = OP_CCLR;
                c_next     = '0;
                k_next     = '0;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                w_idx      = k_reg;
                cmd.op     = OP_CMUL;
                state_next = S_CACC;
            end
            S_CACC:
            begin
                cmd.op = OP_CACC;
                if (k_reg == last_idx)
                    state_next = S_CSTORE;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CMUL;
                end
            end
            S_CSTORE:
            begin
                cmd.op = OP_CSTORE;
                if (c_reg == last_ch)
                    state_next = S_EMIT;
                else
                begin
                    c_next     = c_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_CMUL;
                end
            end
            S_EMIT:
            begin
                t_idx   = lim_idx;
                cmd.op  = OP_EMIT;
                cmd.cap = cap;
                if (stat.out_free)
                begin
                    n_next = n_reg + 1'b1;
                    if (stat.next_skip)
                        state_next = S_SWAIT;
                    else if (stat.next_last)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = '0;
                        state_next = S_NODE;
                    end
                end
            end
            S_SWAIT:
            begin
                t_idx  = lim_idx;
                cmd.op = OP_SFIX;
                if (stat.div_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            n_reg     <= n_next;
        end
    end
endmodule

// ----- design/lgr_dp.sv -----
module lgr_dp #(
    parameter int MAX_ORDER = lgr_pkg::MAX_ORDER_DEF,
    parameter int CHANNELS  = lgr_pkg::CHANNELS_DEF,
    parameter int IDX_W     = $clog2(MAX_ORDER),
    parameter int FC_W      = $clog2(MAX_ORDER + 1),
    parameter int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lgr_pkg::lgr_cmd_t                cmd,
    input  logic [IDX_W-1:0]                 t_idx,
    input  logic [IDX_W-1:0]                 w_idx,
    input  logic [CH_W-1:0]                  ch_idx,
    input  logic [FC_W-1:0]                  ord,
    input  logic [lgr_pkg::TIME_W-1:0]       start_time,
    input  logic [lgr_pkg::TIME_W-1:0]       time_step,
    input  logic                             order_wr,
    input  logic [lgr_pkg::TIME_W-1:0]       in_time,
    input  logic signed [lgr_pkg::VAL_W-1:0] in_vals [lgr_pkg::N_PORTS],
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [lgr_pkg::TIME_W-1:0]       out_time,
    output logic signed [lgr_pkg::VAL_W-1:0] out_vals [lgr_pkg::N_PORTS],
    output logic                             out_last,
    output logic                             out_skip,
    output lgr_pkg::lgr_stat_t               stat
);
    import lgr_pkg::*;

    localparam int PROD_W = MAG_W + VAL_W;
    localparam int TERM_W = PROD_W - WFRAC;
    localparam int ACC_W  = TERM_W + $clog2(MAX_ORDER) + 1;
    localparam logic [MAG_W-1:0] MAGCAP = '1;
    localparam logic [MAG_W-1:0] W_ONE  = MAG_W'(1) << WFRAC;
    localparam logic [PROD_W-1:0] W_HALF = PROD_W'(1) << (WFRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    logic [TIME_W-1:0]       t_win_reg [MAX_ORDER];
    logic signed [VAL_W-1:0] v_win_reg [CHANNELS][MAX_ORDER];
    logic [FC_W-1:0]         fill_reg;
    logic [GRID_W-1:0]       g_reg;
    logic [TIME_W-1:0]       ti_reg;
    logic                    w_neg_reg;
    logic [MAG_W-1:0]        w_mag_reg;
    logic                    f_neg_reg;
    logic [MAG_W-1:0]        f_mag_reg;
    logic                    wt_neg_reg [MAX_ORDER];
    logic [MAG_W-1:0]        wt_mag_reg [MAX_ORDER];
    logic [PROD_W-1:0]       prod_reg;
    logic                    p_neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] interp_reg [CHANNELS];
    logic                    out_valid_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic signed [VAL_W-1:0] out_interp_reg [CHANNELS];
    logic                    out_last_reg;
    logic                    out_skip_reg;

    logic [TIME_W-1:0]   t_sel;
    logic [TIME_W-1:0]   step_eff;
    logic [GRID_W-1:0]   g_step;
    logic [TIME_W:0]     den;
    logic                den_neg;
    logic [TIME_W-1:0]   den_mag;
    logic [TIME_W+2:0]   num;
    logic                num_neg;
    logic [TIME_W+2:0]   num_mag;
    logic [DIV_NW-1:0]   ratio_num;
    logic                ratio_ovf;
    logic                out_free;
    logic                next_last;
    logic                next_skip;
    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_QW-1:0]   div_den;
    logic                div_done;
    logic [DIV_QW-1:0]   div_quot;
    logic [DIV_QW-1:0]   div_rem;
    logic [PROD_W-1:0]   rounded;
    logic [TERM_W-1:0]   term;
    logic signed [VAL_W-1:0] v_sel;
    logic                v_neg;
    logic [VAL_W-1:0]    v_mag;
    logic [VAL_W-1:0]    acc_sat;

    assign t_sel    = t_win_reg[t_idx];
    assign step_eff = (time_step == '0) ? TIME_W'(1) : time_step;
    assign g_step   = g_reg + GRID_W'(step_eff);

    assign den      = {1'b0, ti_reg} - {1'b0, t_sel};
    assign den_neg  = den[TIME_W];
    assign den_mag  = den_neg ? TIME_W'(-den) : den[TIME_W-1:0];
    assign num      = {1'b0, g_reg} - {3'b0, t_sel};
    assign num_neg  = num[TIME_W+2];
    assign num_mag  = num_neg ? -num : num;
    assign ratio_num = {num_mag[TIME_W:0], {WFRAC{1'b0}}} + DIV_NW'(den_mag >> 1);
    assign ratio_ovf = DIV_QW'(ratio_num[DIV_NW-1:MAG_W]) >= den_mag;

    assign out_free  = !out_valid_reg || out_ready;
    assign next_last = (g_step > GRID_W'(t_sel)) || cmd.cap;
    assign next_skip = cmd.cap && !(g_step > GRID_W'(t_sel));

    assign rounded = prod_reg + W_HALF;
    assign term    = rounded[PROD_W-1:WFRAC];
    assign v_sel   = v_win_reg[ch_idx][w_idx];
    assign v_neg   = v_sel[VAL_W-1];
    assign v_mag   = v_neg ? VAL_W'(-v_sel) : VAL_W'(v_sel);
    assign acc_sat = (acc_reg > SAT_HI) ? SAT_HI[VAL_W-1:0] :
                     (acc_reg < SAT_LO) ? SAT_LO[VAL_W-1:0] : acc_reg[VAL_W-1:0];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = DIV_NW'(t_sel - g_reg[TIME_W-1:0]);
        div_den   = step_eff;
        case (cmd.op)
            OP_GINIT:
            begin
                div_start = start_time < t_sel;
                div_num   = DIV_NW'(t_sel - start_time);
            end
            OP_PAIR:
            begin
                div_start = !(den == '0) && !ratio_ovf;
                div_num   = ratio_num;
                div_den   = den_mag;
            end
            OP_EMIT:
            begin
                div_start = out_free && next_skip;
                div_num   = DIV_NW'(t_sel - g_step[TIME_W-1:0]);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    lgr_div #(
        .NW (DIV_NW),
        .QW (DIV_QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            g_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((cmd.op == OP_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (order_wr)
                fill_reg <= '0;
            else if ((cmd.op == OP_LOAD) && (fill_reg < ord))
                fill_reg <= fill_reg + 1'b1;
            case (cmd.op)
                OP_GINIT:
                begin
                    g_reg <= GRID_W'(start_time);
                end
                OP_GFIX:
                begin
                    if (div_done)
                        g_reg <= GRID_W'(t_sel) - GRID_W'(div_rem)
                               + ((div_rem != '0) ? GRID_W'(step_eff) : '0);
                end
                OP_EMIT:
                begin
                    if (out_free)
                        g_reg <= g_step;
                end
                OP_SFIX:
                begin
                    if (div_done)
                        g_reg <= GRID_W'(t_sel) - GRID_W'(div_rem) + GRID_W'(step_eff);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                for (int k = 0; k < MAX_ORDER; k++)
                begin
                    if (fill_reg < ord)
                    begin
                        if (IDX_W'(k) == IDX_W'(fill_reg))
                        begin
                            t_win_reg[k] <= in_time;
                            for (int c = 0; c < CHANNELS; c++)
                                v_win_reg[c][k] <= in_vals[c];
                        end
                    end
                    else if ((k + 1) < int'(ord))
                    begin
                        t_win_reg[k] <= t_win_reg[(k + 1) % MAX_ORDER];
                        for (int c = 0; c < CHANNELS; c++)
                            v_win_reg[c][k] <= v_win_reg[c][(k + 1) % MAX_ORDER];
                    end
                    else if ((k + 1) == int'(ord))
                    begin
                        t_win_reg[k] <= in_time;
                        for (int c = 0; c < CHANNELS; c++)
                            v_win_reg[c][k] <= in_vals[c];
                    end
                end
            end
            OP_NODE:
            begin
                ti_reg    <= t_sel;
                w_mag_reg <= W_ONE;
                w_neg_reg <= 1'b0;
            end
            OP_PAIR:
            begin
                f_neg_reg <= num_neg ^ den_neg;
                if (den == '0)
                begin
                    w_mag_reg <= '0;
                    w_neg_reg <= 1'b0;
                end
                else if (ratio_ovf)
                    f_mag_reg <= MAGCAP;
            end
            OP_FLOAD:
            begin
                if (div_done)
                    f_mag_reg <= div_quot[MAG_W-1:0];
            end
            OP_FMUL:
            begin
                prod_reg  <= PROD_W'(w_mag_reg) * PROD_W'(f_mag_reg);
                p_neg_reg <= w_neg_reg ^ f_neg_reg;
            end
            OP_WRND:
            begin
                w_mag_reg <= (term > TERM_W'(MAGCAP)) ? MAGCAP : term[MAG_W-1:0];
                w_neg_reg <= p_neg_reg;
            end
            OP_WSTORE:
            begin
                wt_mag_reg[w_idx] <= w_mag_reg;
                wt_neg_reg[w_idx] <= w_neg_reg;
            end
            OP_CCLR:
            begin
                acc_reg <= '0;
                for (int c = 0; c < CHANNELS; c++)
                    interp_reg[c] <= '0;
            end
            OP_CMUL:
            begin
                prod_reg  <= PROD_W'(wt_mag_reg[w_idx]) * PROD_W'(v_mag);
                p_neg_reg <= wt_neg_reg[w_idx] ^ v_neg;
            end
            OP_CACC:
            begin
                if (p_neg_reg)
                    acc_reg <= acc_reg - ACC_W'(term);
                else
                    acc_reg <= acc_reg + ACC_W'(term);
            end
            OP_CSTORE:
            begin
                interp_reg[ch_idx] <= acc_sat;
                acc_reg            <= '0;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_time_reg   <= g_reg[TIME_W-1:0];
                    out_interp_reg <= interp_reg;
                    out_last_reg   <= next_last;
                    out_skip_reg   <= next_skip;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar p = 0; p < N_PORTS; p++)
    begin : g_port
        if (p < CHANNELS)
        begin : g_used
            assign out_vals[p] = out_interp_reg[p];
        end
        else
        begin : g_unused
            assign out_vals[p] = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;
    assign out_last  = out_last_reg;
    assign out_skip  = out_skip_reg;

    assign stat.filling    = fill_reg < ord;
    assign stat.fill_last  = fill_reg == ord - 1'b1;
    assign stat.grid_below = start_time < t_sel;
    assign stat.g_le_lim   = g_reg <= GRID_W'(t_sel);
    assign stat.den_zero   = den == '0;
    assign stat.ratio_ovf  = ratio_ovf;
    assign stat.div_done   = div_done;
    assign stat.out_free   = out_free;
    assign stat.next_last  = next_last;
    assign stat.next_skip  = next_skip;
endmodule

// ----- design/lagrange_resampler.sv -----
// Resamples timestamped samples onto the grid start_time + n * time_step.
// Input transactions arrive on sample_in, results leave on result_out; both are
// valid/ready channels and a transaction completes when valid and ready are high.
// Registers are written over the APB port; the user must write them only while
// the block is idle, as the block itself does not enforce it. A sample that only
// fills the window is taken while the block stays idle and yields nothing. Each
// later sample yields zero or more results; the final one carries last_of_burst,
// and points_skipped when the burst limit dropped grid points. A shared bit-serial
// divider forms each node ratio that does not saturate; finding the first grid
// point and jumping over dropped points also use it.
// sample_in is ready only between samples, so one sample is in work at a time.
// A finished result waits in the output register; if the receiver stalls, the
// next result is still computed but is emitted only once that register is taken.
// Reset empties the window and the output register and restores the register
// defaults: start 0, step 1.0, order 4, one channel.
module lagrange_resampler #(
    parameter int MAX_ORDER = lgr_pkg::MAX_ORDER_DEF,
    parameter int CHANNELS  = lgr_pkg::CHANNELS_DEF,
    parameter int MAX_BURST = lgr_pkg::MAX_BURST_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lgr_in_if.sink                        sample_in,
    lgr_out_if.source                     result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lgr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lgr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import lgr_pkg::*;

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int FC_W  = $clog2(MAX_ORDER + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NCH_W = $clog2(CHANNELS + 1);

    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  step_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [CHSEL_W-1:0] chan_reg;

    logic               wr;
    logic [1:0]         reg_sel;
    logic [FC_W-1:0]    ord;
    logic [NCH_W-1:0]   nch;
    logic               in_fire;
    logic               in_ready;
    lgr_cmd_t           cmd;
    lgr_stat_t          stat;
    logic [IDX_W-1:0]   t_idx;
    logic [IDX_W-1:0]   w_idx;
    logic [CH_W-1:0]    ch_idx;
    logic signed [VAL_W-1:0] in_vals  [N_PORTS];
    logic signed [VAL_W-1:0] out_vals [N_PORTS];

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            step_reg  <= TIME_W'(65536);
            order_reg <= ORDER_W'(4);
            chan_reg  <= CHSEL_W'(1);
        end
        else if (wr)
        begin
            case (reg_sel)
                REG_START: start_reg <= pwdata[TIME_W-1:0];
                REG_STEP:  step_reg  <= pwdata[TIME_W-1:0];
                REG_ORDER: order_reg <= pwdata[ORDER_W-1:0];
                REG_CHAN:  chan_reg  <= pwdata[CHSEL_W-1:0];
                default:   start_reg <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START: prdata = PDATA_W'(start_reg);
            REG_STEP:  prdata = PDATA_W'(step_reg);
            REG_ORDER: prdata = PDATA_W'(order_reg);
            REG_CHAN:  prdata = PDATA_W'(chan_reg);
            default:   prdata = '0;
        endcase
    end

    assign ord = (order_reg < ORDER_W'(2)) ? FC_W'(2) :
                 (int'(order_reg) > MAX_ORDER) ? FC_W'(MAX_ORDER) : FC_W'(order_reg);
    assign nch = (chan_reg == '0) ? NCH_W'(1) :
                 (int'(chan_reg) > CHANNELS) ? NCH_W'(CHANNELS) : NCH_W'(chan_reg);

    assign sample_in.ready = in_ready;
    assign in_fire         = sample_in.valid && in_ready;
    assign in_vals[0]      = sample_in.value_a;
    assign in_vals[1]      = sample_in.value_b;
    assign in_vals[2]      = sample_in.value_c;
    assign in_vals[3]      = sample_in.value_d;

    lgr_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .CHANNELS  (CHANNELS),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .ord      (ord),
        .nch      (nch),
        .stat     (stat),
        .cmd      (cmd),
        .t_idx    (t_idx),
        .w_idx    (w_idx),
        .ch_idx   (ch_idx),
        .in_ready (in_ready)
    );

    lgr_dp #(
        .MAX_ORDER (MAX_ORDER),
        .CHANNELS  (CHANNELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .t_idx      (t_idx),
        .w_idx      (w_idx),
        .ch_idx     (ch_idx),
        .ord        (ord),
        .start_time (start_reg),
        .time_step  (step_reg),
        .order_wr   (wr && (reg_sel == REG_ORDER)),
        .in_time    (sample_in.sample_time),
        .in_vals    (in_vals),
        .out_ready  (result_out.ready),
        .out_valid  (result_out.valid),
        .out_time   (result_out.grid_time_out),
        .out_vals   (out_vals),
        .out_last   (result_out.last_of_burst),
        .out_skip   (result_out.points_skipped),
        .stat       (stat)
    );

    assign result_out.interp_a = out_vals[0];
    assign result_out.interp_b = out_vals[1];
    assign result_out.interp_c = out_vals[2];
    assign result_out.interp_d = out_vals[3];
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lgr_pkg::*;

    localparam longint unsigned MAGCAP   = 64'h7FFF_FFFF;
    localparam longint unsigned NOCAP    = '1;
    localparam longint unsigned HALF_W   = 64'd1 << (WFRAC - 1);
    localparam longint unsigned GRID_MSK = 64'hFFFF_FFFF_FFFF;
    localparam int              WD_LIMIT = 60000;
    localparam int              SETTLE   = 2600;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } sample_t;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               last;
        logic               skip;
    } point_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    lgr_in_if  in_if();
    lgr_out_if out_if();

    lagrange_resampler u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_if),
        .result_out (out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow of the block's registers and window.
    longint unsigned cfg_start;
    longint unsigned cfg_step;
    longint unsigned cfg_order;
    longint unsigned cfg_chan;
    longint unsigned win_t [MAX_ORDER_DEF];
    longint          win_v [CHANNELS_DEF][MAX_ORDER_DEF];
    int unsigned     fill_cnt;
    longint unsigned grid_pos;

    point_t pending_points[$];
    int     errors;
    int     samples_sent;
    int     points_seen;
    int     capped_bursts;
    bit     idle_en;
    bit     hold_req;
    int     quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned umag(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint fx_mul(longint a, longint b, longint unsigned cap);
        longint unsigned m;
        m = (umag(a) * umag(b) + HALF_W) >> WFRAC;
        if (m > cap)
        begin
            m = cap;
        end
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_ratio(longint num, longint den);
        longint unsigned mn;
        longint unsigned md;
        longint unsigned q;
        mn = umag(num);
        md = umag(den);
        q  = ((mn << WFRAC) + md / 2) / md;
        if (q > MAGCAP)
        begin
            q = MAGCAP;
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void load_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_START: cfg_start = val;
            REG_STEP:  cfg_step  = val;
            REG_ORDER:
            begin
                cfg_order = val[3:0];
                fill_cnt  = 0;
            end
            default:   cfg_chan  = val[2:0];
        endcase
    endfunction

    // Works out the grid points that one accepted sample produces.
    function automatic void resample(sample_t s);
        int unsigned     ord;
        int unsigned     nch;
        int unsigned     mid;
        int unsigned     lim;
        int              n;
        longint unsigned stp;
        longint unsigned g;
        longint unsigned limt;
        longint          w [MAX_ORDER_DEF];
        longint          acc;
        longint          den;
        longint          sum [CHANNELS_DEF];
        logic [31:0]     vin [CHANNELS_DEF];
        point_t          p;
        point_t          burst[$];
        bit              skipped;

        ord = (cfg_order < 2) ? 2 : ((cfg_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : cfg_order);
        nch = (cfg_chan < 1) ? 1 : ((cfg_chan > CHANNELS_DEF) ? CHANNELS_DEF : cfg_chan);
        mid = ord / 2;
        stp = (cfg_step != 0) ? cfg_step : 1;
        vin = '{s.a, s.b, s.c, s.d};
        n = 0;
        skipped = 1'b0;

        if (fill_cnt < ord)
        begin
            win_t[fill_cnt] = s.t;
            for (int c = 0; c < CHANNELS_DEF; c++)
            begin
                win_v[c][fill_cnt] = longint'(signed'(vin[c]));
            end
            fill_cnt++;
            if (fill_cnt < ord)
            begin
                return;
            end
            g = cfg_start;
            if (g < win_t[mid])
            begin
                g += ((win_t[mid] - g + stp - 1) / stp) * stp;
            end
        end
        else
        begin
            for (int k = 0; k + 1 < ord; k++)
            begin
                win_t[k] = win_t[k + 1];
                for (int c = 0; c < CHANNELS_DEF; c++)
                begin
                    win_v[c][k] = win_v[c][k + 1];
                end
            end
            win_t[ord - 1] = s.t;
            for (int c = 0; c < CHANNELS_DEF; c++)
            begin
                win_v[c][ord - 1] = longint'(signed'(vin[c]));
            end
            g = grid_pos;
        end

        lim = mid + 1;
        if (lim > ord - 1)
        begin
            lim = ord - 1;
        end
        limt = win_t[lim];

        while (g <= limt && n < MAX_BURST_DEF)
        begin
            for (int i = 0; i < ord; i++)
            begin
                acc = longint'(1) << WFRAC;
                for (int j = 0; j < ord; j++)
                begin
                    if (j != i)
                    begin
                        den = longint'(win_t[i]) - longint'(win_t[j]);
                        if (den == 0)
                        begin
                            acc = 0;
                            break;
                        end
                        acc = fx_mul(acc, fx_ratio(longint'(g) - longint'(win_t[j]), den),
                                     MAGCAP);
                    end
                end
                w[i] = acc;
            end
            for (int c = 0; c < CHANNELS_DEF; c++)
            begin
                sum[c] = 0;
                if (c < nch)
                begin
                    for (int k = 0; k < ord; k++)
                    begin
                        sum[c] += fx_mul(w[k], win_v[c][k], NOCAP);
                    end
                    if (sum[c] > 64'sd2147483647)
                    begin
                        sum[c] = 64'sd2147483647;
                    end
                    if (sum[c] < -64'sd2147483648)
                    begin
                        sum[c] = -64'sd2147483648;
                    end
                end
            end
            p.t    = g[31:0];
            p.a    = sum[0][31:0];
            p.b    = sum[1][31:0];
            p.c    = sum[2][31:0];
            p.d    = sum[3][31:0];
            p.last = 1'b0;
            p.skip = 1'b0;
            burst.push_back(p);
            g += stp;
            n++;
        end
        if (g <= limt)
        begin
            g += ((limt - g) / stp + 1) * stp;
            skipped = 1'b1;
            capped_bursts++;
        end
        grid_pos = g & GRID_MSK;
        if (n > 0)
        begin
            burst[n - 1].last = 1'b1;
            burst[n - 1].skip = skipped;
        end
        foreach (burst[i])
        begin
            pending_points.push_back(burst[i]);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        load_reg(idx, val);
    endtask

    task automatic drain();
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_sample(sample_t s);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample_time <= s.t;
        in_if.value_a     <= s.a;
        in_if.value_b     <= s.b;
        in_if.value_c     <= s.c;
        in_if.value_d     <= s.d;
        do
        begin
            @(posedge clk);
        end
        while (!in_if.ready);
        samples_sent++;
        resample(s);
    endtask

    task automatic send_at(logic [31:0] t, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
        send_sample('{t, a, b, c, d});
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
    endtask

    task automatic test_defaults();
        send_at(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_at(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_at(32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_at(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_at(32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h5555_AAAA);
        stop_sending();
        drain();
    endtask

    // Order two with a zero step, taken as a step of one; the last sample yields a full burst.
    task automatic test_burst_cap();
        write_reg(REG_ORDER, 32'd0);
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_CHAN, 32'd7);
        write_reg(REG_START, 32'h0000_0000);
        send_at(32'h0000_0010, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_at(32'h0000_0100, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h8000_0000);
        send_at(32'h0000_0140, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
        stop_sending();
        drain();
    endtask

    task automatic test_equal_times();
        write_reg(REG_STEP, 32'h0000_4000);
        write_reg(REG_ORDER, 32'd3);
        write_reg(REG_CHAN, 32'd2);
        send_at(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_at(32'h0001_0000, 32'h0005_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        send_at(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_at(32'h0003_0000, 32'h0004_0000, 32'h0007_0000, 32'h0, 32'h0);
        send_at(32'h0003_0000, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0);
        stop_sending();
        drain();
    endtask

    // Orders above the maximum clamp to eight; alternating extremes saturate.
    task automatic test_order_max();
        write_reg(REG_ORDER, 32'd15);
        write_reg(REG_CHAN, 32'd4);
        write_reg(REG_STEP, 32'h0000_C000);
        write_reg(REG_START, 32'hFFF0_0000);
        for (int i = 0; i < 10; i++)
        begin
            send_at(32'hFFF0_0000 + i * 32'h0001_0000,
                    i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                    i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                    i * 32'h0001_0000, 32'h0);
        end
        stop_sending();
        drain();
    endtask

    // A new start time only counts once the window fills again.
    task automatic test_start_midstream();
        write_reg(REG_ORDER, 32'd1);
        write_reg(REG_STEP, 32'h0001_0000);
        write_reg(REG_START, 32'h0000_8000);
        send_at(32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_at(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h0);
        stop_sending();
        drain();
        write_reg(REG_START, 32'h0010_0000);
        send_at(32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
        stop_sending();
        drain();
        write_reg(REG_ORDER, 32'd2);
        send_at(32'h000F_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_at(32'h0011_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h0);
        stop_sending();
        drain();
    endtask

    task automatic random_phase(int count, int ord, bit hold);
        longint unsigned t;
        longint unsigned stp;
        sample_t         s;
        write_reg(REG_ORDER, ord);
        write_reg(REG_CHAN, $urandom_range(0, 7));
        write_reg(REG_STEP, $urandom_range(32'h0000_4000, 32'h0003_0000));
        t = $urandom_range(0, 32'h8000_0000);
        write_reg(REG_START, 32'(t + $urandom_range(0, 32'h0004_0000)));
        stp = cfg_step;
        if (hold)
        begin
            hold_req = 1'b1;
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                t = t - $urandom_range(0, stp);
            end
            else
            begin
                t = t + stp * $urandom_range(0, 2) + $urandom_range(1, stp);
            end
            if (t > 64'hFFFF_FFFF)
            begin
                t = 64'hFFFF_FFFF;
            end
            s.t = t[31:0];
            s.a = $urandom();
            s.b = $urandom();
            s.c = $urandom();
            s.d = $urandom();
            if ($urandom_range(0, 2) == 0)
            begin
                s.a = {{12{s.a[31]}}, s.a[19:0]};
            end
            send_sample(s);
        end
        stop_sending();
        drain();
    endtask

    task automatic test_random();
        random_phase(60, $urandom_range(2, 4), 1'b0);
        random_phase(50, $urandom_range(3, 5), 1'b1);
        random_phase(20, 7, 1'b0);
        random_phase(50, 2, 1'b0);
        idle_en = 1'b0;
        random_phase(50, $urandom_range(2, 4), 1'b0);
    endtask

    // Result checking, receiver stalls and the watchdog.
    initial
    begin : result_check
        int     stall_left;
        int     hold_left;
        bit     take;
        point_t want;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_points.size());
                $display("RESULT: ERROR");
                $finish;
            end
            if (rst_n && out_if.valid && out_if.ready)
            begin
                points_seen++;
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected transaction t=%h", $time, out_if.grid_time_out);
                    errors++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (out_if.grid_time_out !== want.t)
                    begin
                        $display("%0t: grid_time_out exp %h got %h", $time, want.t,
                                 out_if.grid_time_out);
                        errors++;
                    end
                    if (out_if.interp_a !== want.a)
                    begin
                        $display("%0t: interp_a exp %h got %h", $time, want.a, out_if.interp_a);
                        errors++;
                    end
                    if (out_if.interp_b !== want.b)
                    begin
                        $display("%0t: interp_b exp %h got %h", $time, want.b, out_if.interp_b);
                        errors++;
                    end
                    if (out_if.interp_c !== want.c)
                    begin
                        $display("%0t: interp_c exp %h got %h", $time, want.c, out_if.interp_c);
                        errors++;
                    end
                    if (out_if.interp_d !== want.d)
                    begin
                        $display("%0t: interp_d exp %h got %h", $time, want.d, out_if.interp_d);
                        errors++;
                    end
                    if (out_if.last_of_burst !== want.last)
                    begin
                        $display("%0t: last_of_burst exp %b got %b", $time, want.last,
                                 out_if.last_of_burst);
                        errors++;
                    end
                    if (out_if.points_skipped !== want.skip)
                    begin
                        $display("%0t: points_skipped exp %b got %b", $time, want.skip,
                                 out_if.points_skipped);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
            end
            out_if.ready <= take;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.sample_time = '0;
        in_if.value_a     = '0;
        in_if.value_b     = '0;
        in_if.value_c     = '0;
        in_if.value_d     = '0;
        out_if.ready      = 1'b0;
        errors            = 0;
        samples_sent      = 0;
        points_seen       = 0;
        capped_bursts     = 0;
        quiet_cycles      = 0;
        hold_req          = 1'b0;
        idle_en           = 1'b1;
        cfg_start         = 0;
        cfg_step          = 65536;
        cfg_order         = 4;
        cfg_chan          = 1;
        fill_cnt          = 0;
        grid_pos          = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_burst_cap();
        test_equal_times();
        test_order_max();
        test_start_midstream();
        test_random();

        $display("Sent %0d samples, checked %0d grid points, %0d bursts hit the cap.",
                 samples_sent, points_seen, capped_bursts);
        $display("Orders two to eight, clamped registers, zero step and receiver hold-off run.");
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
